// ===== rtl/mvcp_pkg.sv =====
// ============================================================================
// mvcp_pkg: shared constants, codes and lookup tables
// Style codes, family bases and periods, and the hole and Arabic tables of
// the math variant code point map.
// ============================================================================
`default_nettype none

package mvcp_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned ModeWidth = 5;

   // Style selector codes
   localparam logic [ModeWidth-1:0] ModeNormal        = 5'd0;
   localparam logic [ModeWidth-1:0] ModeBold          = 5'd1;
   localparam logic [ModeWidth-1:0] ModeItalic        = 5'd2;
   localparam logic [ModeWidth-1:0] ModeBoldItalic    = 5'd3;
   localparam logic [ModeWidth-1:0] ModeDouble        = 5'd7;
   localparam logic [ModeWidth-1:0] ModeSans          = 5'd9;
   localparam logic [ModeWidth-1:0] ModeBoldSans      = 5'd10;
   localparam logic [ModeWidth-1:0] ModeSansBoldItal  = 5'd12;
   localparam logic [ModeWidth-1:0] ModeMono          = 5'd13;
   localparam logic [ModeWidth-1:0] ModeInitial       = 5'd14;
   localparam logic [ModeWidth-1:0] ModeTailed        = 5'd15;
   localparam logic [ModeWidth-1:0] ModeLooped        = 5'd16;
   localparam logic [ModeWidth-1:0] ModeStretched     = 5'd17;

   // Family bases and periods
   localparam logic [CpWidth-1:0] LatBase     = 21'h1D400;
   localparam logic [CpWidth-1:0] LatPeriod   = 21'h1D434 - 21'h1D400;
   localparam logic [CpWidth-1:0] LatSmallOfs = 21'h1D41A - 21'h1D400;
   localparam logic [CpWidth-1:0] GrkBase     = 21'h1D6A8;
   localparam logic [CpWidth-1:0] GrkSmallOfs = 21'h1D6C2 - 21'h1D6A8;
   localparam logic [CpWidth-1:0] GrkPeriod   = 21'h1D6E2 - 21'h1D6A8;
   localparam logic [CpWidth-1:0] DigBase     = 21'h1D7CE;
   localparam logic [CpWidth-1:0] DigPeriod   = 21'h1D7D8 - 21'h1D7CE;

   typedef struct packed {
      logic               hit;
      logic [CpWidth-1:0] val;
   } lookup_type;

   // Latin results that land on a hole in the math block
   function automatic lookup_type hole_lookup(input logic [CpWidth-1:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         21'h1D455: r.val = 21'h210E;
         21'h1D49D: r.val = 21'h212C;
         21'h1D4A0: r.val = 21'h2130;
         21'h1D4A1: r.val = 21'h2131;
         21'h1D4A3: r.val = 21'h210B;
         21'h1D4A4: r.val = 21'h2110;
         21'h1D4A7: r.val = 21'h2112;
         21'h1D4A8: r.val = 21'h2133;
         21'h1D4AD: r.val = 21'h211B;
         21'h1D4BA: r.val = 21'h212F;
         21'h1D4BC: r.val = 21'h210A;
         21'h1D4C4: r.val = 21'h2134;
         21'h1D506: r.val = 21'h212D;
         21'h1D50B: r.val = 21'h210C;
         21'h1D50C: r.val = 21'h2111;
         21'h1D515: r.val = 21'h211C;
         21'h1D51D: r.val = 21'h2128;
         21'h1D53A: r.val = 21'h2102;
         21'h1D53F: r.val = 21'h210D;
         21'h1D545: r.val = 21'h2115;
         21'h1D547: r.val = 21'h2119;
         21'h1D548: r.val = 21'h211A;
         21'h1D549: r.val = 21'h211D;
         21'h1D551: r.val = 21'h2124;
         default: begin
            r.hit = 1'b0;
            r.val = key;
         end
      endcase
      return r;
   endfunction

   // Arabic tables, keyed by the low byte inside the 0x06xx block
   function automatic lookup_type ar_initial(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h28: r.val = 21'h1EE21;
         8'h2A: r.val = 21'h1EE35;
         8'h2B: r.val = 21'h1EE36;
         8'h2C: r.val = 21'h1EE22;
         8'h2D: r.val = 21'h1EE27;
         8'h2E: r.val = 21'h1EE37;
         8'h33: r.val = 21'h1EE2E;
         8'h34: r.val = 21'h1EE34;
         8'h35: r.val = 21'h1EE31;
         8'h36: r.val = 21'h1EE39;
         8'h39: r.val = 21'h1EE2F;
         8'h3A: r.val = 21'h1EE3B;
         8'h41: r.val = 21'h1EE30;
         8'h42: r.val = 21'h1EE32;
         8'h43: r.val = 21'h1EE2A;
         8'h44: r.val = 21'h1EE2B;
         8'h45: r.val = 21'h1EE2C;
         8'h46: r.val = 21'h1EE2D;
         8'h47: r.val = 21'h1EE24;
         8'h4A: r.val = 21'h1EE29;
         default: begin
            r.hit = 1'b0;
            r.val = '0;
         end
      endcase
      return r;
   endfunction

   function automatic lookup_type ar_tailed(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h2C: r.val = 21'h1EE42;
         8'h2D: r.val = 21'h1EE47;
         8'h2E: r.val = 21'h1EE57;
         8'h33: r.val = 21'h1EE4E;
         8'h34: r.val = 21'h1EE54;
         8'h35: r.val = 21'h1EE51;
         8'h36: r.val = 21'h1EE59;
         8'h39: r.val = 21'h1EE4F;
         8'h3A: r.val = 21'h1EE5B;
         8'h42: r.val = 21'h1EE52;
         8'h44: r.val = 21'h1EE4B;
         8'h46: r.val = 21'h1EE4D;
         8'h4A: r.val = 21'h1EE49;
         8'h6F: r.val = 21'h1EE5F;
         8'hBA: r.val = 21'h1EE5D;
         default: begin
            r.hit = 1'b0;
            r.val = '0;
         end
      endcase
      return r;
   endfunction

   function automatic lookup_type ar_stretched(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h28: r.val = 21'h1EE61;
         8'h2A: r.val = 21'h1EE75;
         8'h2B: r.val = 21'h1EE76;
         8'h2C: r.val = 21'h1EE62;
         8'h2D: r.val = 21'h1EE67;
         8'h2E: r.val = 21'h1EE77;
         8'h33: r.val = 21'h1EE6E;
         8'h34: r.val = 21'h1EE74;
         8'h35: r.val = 21'h1EE71;
         8'h36: r.val = 21'h1EE79;
         8'h37: r.val = 21'h1EE68;
         8'h38: r.val = 21'h1EE7A;
         8'h39: r.val = 21'h1EE6F;
         8'h3A: r.val = 21'h1EE7B;
         8'h41: r.val = 21'h1EE70;
         8'h42: r.val = 21'h1EE72;
         8'h43: r.val = 21'h1EE6A;
         8'h45: r.val = 21'h1EE6C;
         8'h46: r.val = 21'h1EE6D;
         8'h47: r.val = 21'h1EE64;
         8'h4A: r.val = 21'h1EE69;
         8'h6E: r.val = 21'h1EE7C;
         8'hA1: r.val = 21'h1EE7E;
         default: begin
            r.hit = 1'b0;
            r.val = '0;
         end
      endcase
      return r;
   endfunction

   function automatic lookup_type ar_looped(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h27: r.val = 21'h1EE80;
         8'h28: r.val = 21'h1EE81;
         8'h2A: r.val = 21'h1EE95;
         8'h2B: r.val = 21'h1EE96;
         8'h2C: r.val = 21'h1EE82;
         8'h2D: r.val = 21'h1EE87;
         8'h2E: r.val = 21'h1EE97;
         8'h2F: r.val = 21'h1EE83;
         8'h30: r.val = 21'h1EE98;
         8'h31: r.val = 21'h1EE93;
         8'h32: r.val = 21'h1EE86;
         8'h33: r.val = 21'h1EE8E;
         8'h34: r.val = 21'h1EE94;
         8'h35: r.val = 21'h1EE91;
         8'h36: r.val = 21'h1EE99;
         8'h37: r.val = 21'h1EE88;
         8'h38: r.val = 21'h1EE9A;
         8'h39: r.val = 21'h1EE8F;
         8'h3A: r.val = 21'h1EE9B;
         8'h41: r.val = 21'h1EE90;
         8'h42: r.val = 21'h1EE92;
         8'h44: r.val = 21'h1EE8B;
         8'h45: r.val = 21'h1EE8C;
         8'h46: r.val = 21'h1EE8D;
         8'h47: r.val = 21'h1EE84;
         8'h48: r.val = 21'h1EE85;
         8'h4A: r.val = 21'h1EE89;
         default: begin
            r.hit = 1'b0;
            r.val = '0;
         end
      endcase
      return r;
   endfunction

   function automatic lookup_type ar_double(input logic [7:0] key);
      lookup_type r;
      r.hit = 1'b1;
      case (key)
         8'h28: r.val = 21'h1EEA1;
         8'h2A: r.val = 21'h1EEB5;
         8'h2B: r.val = 21'h1EEB6;
         8'h2C: r.val = 21'h1EEA2;
         8'h2D: r.val = 21'h1EEA7;
         8'h2E: r.val = 21'h1EEB7;
         8'h2F: r.val = 21'h1EEA3;
         8'h30: r.val = 21'h1EEB8;
         8'h31: r.val = 21'h1EEB3;
         8'h32: r.val = 21'h1EEA6;
         8'h33: r.val = 21'h1EEAE;
         8'h34: r.val = 21'h1EEB4;
         8'h35: r.val = 21'h1EEB1;
         8'h36: r.val = 21'h1EEB9;
         8'h37: r.val = 21'h1EEA8;
         8'h38: r.val = 21'h1EEBA;
         8'h39: r.val = 21'h1EEAF;
         8'h3A: r.val = 21'h1EEBB;
         8'h41: r.val = 21'h1EEB0;
         8'h42: r.val = 21'h1EEB2;
         8'h44: r.val = 21'h1EEAB;
         8'h45: r.val = 21'h1EEAC;
         8'h46: r.val = 21'h1EEAD;
         8'h48: r.val = 21'h1EEA5;
         8'h4A: r.val = 21'h1EEA9;
         default: begin
            r.hit = 1'b0;
            r.val = '0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/math_variant_code_point_map.sv =====
// ============================================================================
// math_variant_code_point_map: styled math code point lookup
// Top level: input register, mapping logic, result register.
// ============================================================================
// How to use:
//   Request channel: drive req_code_point and req_mode and raise start. A
//   word is taken at each rising edge where start is high and busy is low.
//   busy never rises, so a new word can be sent in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle with the styled
//   point on rsp_mapped_point; there is no backpressure, so the receiver
//   must take the word in that cycle.
//   Path: an accepted word is held in the input register, then passes
//   through the mapping into the result register, which drives the
//   result ports.
//   Throughput: one word per cycle, set by the single
//   pass through the classify, multiply-add and table logic.
//   Results leave in the order words were accepted.
//   Reset: synchronous and active high; it drops any word in flight and
//   clears both valid flags. There is no state beyond the pipeline.
// ============================================================================
`default_nettype none

module math_variant_code_point_map
   import mvcp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CpWidth-1:0]   req_code_point,
   input  wire logic [ModeWidth-1:0] req_mode,
   output logic                      rsp_valid,
   output logic      [CpWidth-1:0]   rsp_mapped_point
);

   logic                 req_valid_ff;
   logic                 req_valid_in;
   logic [CpWidth-1:0]   req_cp_ff;
   logic [ModeWidth-1:0] req_mode_ff;
   logic [CpWidth-1:0]   map_point;
   logic                 rsp_valid_ff;
   logic [CpWidth-1:0]   rsp_point_ff;

   // never stall: the pipeline advances every cycle
   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   // hold the accepted word in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_cp_ff   <= req_code_point;
         req_mode_ff <= req_mode;
      end
   end

   mvcp_map u_map (
      .code_point   (req_cp_ff),
      .mode         (req_mode_ff),
      .mapped_point (map_point)
   );

   // advance into the result register; strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_point_ff <= map_point;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_point = rsp_point_ff;

endmodule

`default_nettype wire

// ===== rtl/mvcp_map.sv =====
// ============================================================================
// mvcp_map: combinational style mapping of one code point
// Classes the code point, forms the styled point and applies the hole and
// Arabic tables.
// ============================================================================
`default_nettype none

module mvcp_map
   import mvcp_pkg::*;
(
   input  wire logic [CpWidth-1:0]   code_point,
   input  wire logic [ModeWidth-1:0] mode,
   output logic      [CpWidth-1:0]   mapped_point
);

   logic               is_upper;
   logic               is_lower;
   logic               is_digit;
   logic               is_arabic;
   logic [CpWidth-1:0] lat_ofs;
   logic [CpWidth-1:0] lat_point;
   lookup_type         hole;
   lookup_type         arab;
   logic               grk_hit;
   logic [CpWidth-1:0] grk_ofs;

   assign is_upper  = (code_point >= 21'h41) && (code_point <= 21'h5A);
   assign is_lower  = (code_point >= 21'h61) && (code_point <= 21'h7A);
   assign is_digit  = (code_point >= 21'h30) && (code_point <= 21'h39);
   assign is_arabic = (code_point[CpWidth-1:8] == 13'h006);

   assign lat_ofs   = is_upper ? (code_point - 21'h41) : (LatSmallOfs + code_point - 21'h61);
   assign lat_point = LatBase + CpWidth'(mode - 5'd1) * LatPeriod + lat_ofs;
   assign hole      = hole_lookup(lat_point);

   always_comb begin
      case (mode)
         ModeInitial:   arab = ar_initial(code_point[7:0]);
         ModeTailed:    arab = ar_tailed(code_point[7:0]);
         ModeStretched: arab = ar_stretched(code_point[7:0]);
         ModeLooped:    arab = ar_looped(code_point[7:0]);
         ModeDouble:    arab = ar_double(code_point[7:0]);
         default:       arab = '0;
      endcase
   end

   // Greek letters and symbols: offset inside the Greek family
   always_comb begin
      grk_hit = 1'b1;
      grk_ofs = '0;
      if ((code_point >= 21'h391) && (code_point <= 21'h3A9)) begin
         grk_ofs = code_point - 21'h391;
      end else if ((code_point >= 21'h3B1) && (code_point <= 21'h3C9)) begin
         grk_ofs = GrkSmallOfs + code_point - 21'h3B1;
      end else begin
         case (code_point)
            21'h03F4: grk_ofs = 21'h11;
            21'h2207: grk_ofs = 21'h19;
            21'h2202: grk_ofs = 21'h33;
            21'h03F5: grk_ofs = 21'h34;
            21'h03D1: grk_ofs = 21'h35;
            21'h03F0: grk_ofs = 21'h36;
            21'h03D5: grk_ofs = 21'h37;
            21'h03F1: grk_ofs = 21'h38;
            21'h03D6: grk_ofs = 21'h39;
            default:  grk_hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      mapped_point = code_point;
      if ((mode == ModeNormal) || (mode > ModeStretched)) begin
         mapped_point = code_point;
      end else if (code_point == 21'h03A2) begin
         mapped_point = code_point;
      end else if ((code_point == 21'h03DC) || (code_point == 21'h03DD)) begin
         // digamma: bold only
         if (mode == ModeBold) begin
            mapped_point = {20'h0EBE5, code_point[0]};
         end
      end else if ((code_point == 21'h0131) || (code_point == 21'h0237)) begin
         // dotless i and j: italic only
         if (mode == ModeItalic) begin
            mapped_point = (code_point == 21'h0131) ? 21'h1D6A4 : 21'h1D6A5;
         end
      end else if (is_upper || is_lower) begin
         if (mode <= ModeMono) begin
            mapped_point = hole.hit ? hole.val : lat_point;
         end
      end else if (is_digit) begin
         case (mode)
            ModeBold:     mapped_point = DigBase + code_point - 21'h30;
            ModeDouble:   mapped_point = DigBase + DigPeriod + code_point - 21'h30;
            ModeSans:     mapped_point = DigBase + 21'd2 * DigPeriod + code_point - 21'h30;
            ModeBoldSans: mapped_point = DigBase + 21'd3 * DigPeriod + code_point - 21'h30;
            ModeMono:     mapped_point = DigBase + 21'd4 * DigPeriod + code_point - 21'h30;
            default:      mapped_point = code_point;
         endcase
      end else if (is_arabic) begin
         if (arab.hit) begin
            mapped_point = arab.val;
         end
      end else if (grk_hit) begin
         case (mode)
            ModeBold:         mapped_point = GrkBase + grk_ofs;
            ModeItalic:       mapped_point = GrkBase + GrkPeriod + grk_ofs;
            ModeBoldItalic:   mapped_point = GrkBase + 21'd2 * GrkPeriod + grk_ofs;
            ModeBoldSans:     mapped_point = GrkBase + 21'd3 * GrkPeriod + grk_ofs;
            ModeSansBoldItal: mapped_point = GrkBase + 21'd4 * GrkPeriod + grk_ofs;
            default:          mapped_point = code_point;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== tb/mapped_point_checker.sv =====
// ============================================================================
// mapped_point_checker: predicts and checks styled math code points
// Watches the request and result channels of the math variant code point
// map, computes the styled point of every accepted word and compares each
// result, in order, against the oldest prediction.
// ============================================================================
`default_nettype none

module mapped_point_checker
   import mvcp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [CpWidth-1:0]   req_code_point,
   input  wire logic [ModeWidth-1:0] req_mode,
   input  wire logic                 rsp_valid,
   input  wire logic [CpWidth-1:0]   rsp_mapped_point,
   output int unsigned               mismatches,
   output int unsigned               outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CpWidth-1:0] LatinBase   = 21'h1D400;
   localparam logic [CpWidth-1:0] LatinStride = 21'h34;
   localparam logic [CpWidth-1:0] LatinSmall  = 21'h1A;
   localparam logic [CpWidth-1:0] GreekBase   = 21'h1D6A8;
   localparam logic [CpWidth-1:0] GreekStride = 21'h3A;
   localparam logic [CpWidth-1:0] GreekSmall  = 21'h1A;
   localparam logic [CpWidth-1:0] DigitBase   = 21'h1D7CE;
   localparam logic [CpWidth-1:0] DigitStride = 21'hA;

   logic [CpWidth-1:0] expected_points [$];
   int unsigned        fail_tally = 0;
   int unsigned        queued     = 0;

   assign mismatches  = fail_tally;
   assign outstanding = queued;

   // Swap a Latin point that falls in a gap of the math block for the
   // letterlike symbol that lives there.
   function automatic logic [CpWidth-1:0] letterlike(input logic [CpWidth-1:0] pt);
      case (pt)
         21'h1D455: return 21'h210E;  21'h1D49D: return 21'h212C;
         21'h1D4A0: return 21'h2130;  21'h1D4A1: return 21'h2131;
         21'h1D4A3: return 21'h210B;  21'h1D4A4: return 21'h2110;
         21'h1D4A7: return 21'h2112;  21'h1D4A8: return 21'h2133;
         21'h1D4AD: return 21'h211B;  21'h1D4BA: return 21'h212F;
         21'h1D4BC: return 21'h210A;  21'h1D4C4: return 21'h2134;
         21'h1D506: return 21'h212D;  21'h1D50B: return 21'h210C;
         21'h1D50C: return 21'h2111;  21'h1D515: return 21'h211C;
         21'h1D51D: return 21'h2128;  21'h1D53A: return 21'h2102;
         21'h1D53F: return 21'h210D;  21'h1D545: return 21'h2115;
         21'h1D547: return 21'h2119;  21'h1D548: return 21'h211A;
         21'h1D549: return 21'h211D;  21'h1D551: return 21'h2124;
         default:   return pt;
      endcase
   endfunction

   // Position inside the Greek family, or -1 for anything else
   function automatic int greek_index(input logic [CpWidth-1:0] cp);
      if (cp >= 21'h391 && cp <= 21'h3A9) return int'(cp - 21'h391);
      if (cp >= 21'h3B1 && cp <= 21'h3C9) return int'(GreekSmall + cp - 21'h3B1);
      case (cp)
         21'h03F4: return 'h11;
         21'h2207: return 'h19;
         21'h2202: return 'h33;
         21'h03F5: return 'h34;
         21'h03D1: return 'h35;
         21'h03F0: return 'h36;
         21'h03D5: return 'h37;
         21'h03F1: return 'h38;
         21'h03D6: return 'h39;
         default:  return -1;
      endcase
   endfunction

   // Arabic letters: one table per style, pass through on a miss
   function automatic logic [CpWidth-1:0] arabic_form(input logic [CpWidth-1:0] cp,
                                                      input logic [ModeWidth-1:0] mode);
      logic [CpWidth-1:0] pt;
      pt = cp;
      case (mode)
         ModeInitial:
            case (cp[7:0])
               8'h28: pt = 21'h1EE21;  8'h2A: pt = 21'h1EE35;  8'h2B: pt = 21'h1EE36;
               8'h2C: pt = 21'h1EE22;  8'h2D: pt = 21'h1EE27;  8'h2E: pt = 21'h1EE37;
               8'h33: pt = 21'h1EE2E;  8'h34: pt = 21'h1EE34;  8'h35: pt = 21'h1EE31;
               8'h36: pt = 21'h1EE39;  8'h39: pt = 21'h1EE2F;  8'h3A: pt = 21'h1EE3B;
               8'h41: pt = 21'h1EE30;  8'h42: pt = 21'h1EE32;  8'h43: pt = 21'h1EE2A;
               8'h44: pt = 21'h1EE2B;  8'h45: pt = 21'h1EE2C;  8'h46: pt = 21'h1EE2D;
               8'h47: pt = 21'h1EE24;  8'h4A: pt = 21'h1EE29;
               default: pt = cp;
            endcase
         ModeTailed:
            case (cp[7:0])
               8'h2C: pt = 21'h1EE42;  8'h2D: pt = 21'h1EE47;  8'h2E: pt = 21'h1EE57;
               8'h33: pt = 21'h1EE4E;  8'h34: pt = 21'h1EE54;  8'h35: pt = 21'h1EE51;
               8'h36: pt = 21'h1EE59;  8'h39: pt = 21'h1EE4F;  8'h3A: pt = 21'h1EE5B;
               8'h42: pt = 21'h1EE52;  8'h44: pt = 21'h1EE4B;  8'h46: pt = 21'h1EE4D;
               8'h4A: pt = 21'h1EE49;  8'h6F: pt = 21'h1EE5F;  8'hBA: pt = 21'h1EE5D;
               default: pt = cp;
            endcase
         ModeStretched:
            case (cp[7:0])
               8'h28: pt = 21'h1EE61;  8'h2A: pt = 21'h1EE75;  8'h2B: pt = 21'h1EE76;
               8'h2C: pt = 21'h1EE62;  8'h2D: pt = 21'h1EE67;  8'h2E: pt = 21'h1EE77;
               8'h33: pt = 21'h1EE6E;  8'h34: pt = 21'h1EE74;  8'h35: pt = 21'h1EE71;
               8'h36: pt = 21'h1EE79;  8'h37: pt = 21'h1EE68;  8'h38: pt = 21'h1EE7A;
               8'h39: pt = 21'h1EE6F;  8'h3A: pt = 21'h1EE7B;  8'h41: pt = 21'h1EE70;
               8'h42: pt = 21'h1EE72;  8'h43: pt = 21'h1EE6A;  8'h45: pt = 21'h1EE6C;
               8'h46: pt = 21'h1EE6D;  8'h47: pt = 21'h1EE64;  8'h4A: pt = 21'h1EE69;
               8'h6E: pt = 21'h1EE7C;  8'hA1: pt = 21'h1EE7E;
               default: pt = cp;
            endcase
         ModeLooped:
            case (cp[7:0])
               8'h27: pt = 21'h1EE80;  8'h28: pt = 21'h1EE81;  8'h2A: pt = 21'h1EE95;
               8'h2B: pt = 21'h1EE96;  8'h2C: pt = 21'h1EE82;  8'h2D: pt = 21'h1EE87;
               8'h2E: pt = 21'h1EE97;  8'h2F: pt = 21'h1EE83;  8'h30: pt = 21'h1EE98;
               8'h31: pt = 21'h1EE93;  8'h32: pt = 21'h1EE86;  8'h33: pt = 21'h1EE8E;
               8'h34: pt = 21'h1EE94;  8'h35: pt = 21'h1EE91;  8'h36: pt = 21'h1EE99;
               8'h37: pt = 21'h1EE88;  8'h38: pt = 21'h1EE9A;  8'h39: pt = 21'h1EE8F;
               8'h3A: pt = 21'h1EE9B;  8'h41: pt = 21'h1EE90;  8'h42: pt = 21'h1EE92;
               8'h44: pt = 21'h1EE8B;  8'h45: pt = 21'h1EE8C;  8'h46: pt = 21'h1EE8D;
               8'h47: pt = 21'h1EE84;  8'h48: pt = 21'h1EE85;  8'h4A: pt = 21'h1EE89;
               default: pt = cp;
            endcase
         ModeDouble:
            case (cp[7:0])
               8'h28: pt = 21'h1EEA1;  8'h2A: pt = 21'h1EEB5;  8'h2B: pt = 21'h1EEB6;
               8'h2C: pt = 21'h1EEA2;  8'h2D: pt = 21'h1EEA7;  8'h2E: pt = 21'h1EEB7;
               8'h2F: pt = 21'h1EEA3;  8'h30: pt = 21'h1EEB8;  8'h31: pt = 21'h1EEB3;
               8'h32: pt = 21'h1EEA6;  8'h33: pt = 21'h1EEAE;  8'h34: pt = 21'h1EEB4;
               8'h35: pt = 21'h1EEB1;  8'h36: pt = 21'h1EEB9;  8'h37: pt = 21'h1EEA8;
               8'h38: pt = 21'h1EEBA;  8'h39: pt = 21'h1EEAF;  8'h3A: pt = 21'h1EEBB;
               8'h41: pt = 21'h1EEB0;  8'h42: pt = 21'h1EEB2;  8'h44: pt = 21'h1EEAB;
               8'h45: pt = 21'h1EEAC;  8'h46: pt = 21'h1EEAD;  8'h48: pt = 21'h1EEA5;
               8'h4A: pt = 21'h1EEA9;
               default: pt = cp;
            endcase
         default: pt = cp;
      endcase
      return pt;
   endfunction

   function automatic logic [CpWidth-1:0] styled_point(input logic [CpWidth-1:0] cp,
                                                       input logic [ModeWidth-1:0] mode);
      logic [CpWidth-1:0] ofs;
      logic [CpWidth-1:0] slot;
      int                 grk;
      if (mode == ModeNormal || mode > ModeStretched) return cp;

      case (cp)
         21'h03A2: return cp;
         21'h03DC: return (mode == ModeBold) ? 21'h1D7CA : cp;
         21'h03DD: return (mode == ModeBold) ? 21'h1D7CB : cp;
         21'h0131: return (mode == ModeItalic) ? 21'h1D6A4 : cp;
         21'h0237: return (mode == ModeItalic) ? 21'h1D6A5 : cp;
         default: ;
      endcase

      if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) begin
         if (mode > ModeMono) return cp;
         ofs = (cp <= 21'h5A) ? cp - 21'h41 : LatinSmall + cp - 21'h61;
         return letterlike(CpWidth'(LatinBase + (mode - 1) * LatinStride + ofs));
      end

      if (cp >= 21'h30 && cp <= 21'h39) begin
         case (mode)
            ModeBold:     slot = 21'd0;
            ModeDouble:   slot = 21'd1;
            ModeSans:     slot = 21'd2;
            ModeBoldSans: slot = 21'd3;
            ModeMono:     slot = 21'd4;
            default:      return cp;
         endcase
         return DigitBase + slot * DigitStride + (cp - 21'h30);
      end

      if (cp >= 21'h600 && cp <= 21'h6FF) return arabic_form(cp, mode);

      grk = greek_index(cp);
      if (grk >= 0) begin
         case (mode)
            ModeBold:         slot = 21'd0;
            ModeItalic:       slot = 21'd1;
            ModeBoldItalic:   slot = 21'd2;
            ModeBoldSans:     slot = 21'd3;
            ModeSansBoldItal: slot = 21'd4;
            default:          return cp;
         endcase
         return GreekBase + slot * GreekStride + CpWidth'(grk);
      end

      return cp;
   endfunction

   always @(posedge clock) begin : watch
      logic [CpWidth-1:0] want;
      if (!reset) begin
         if (start && !busy)
            expected_points.push_back(styled_point(req_code_point, req_mode));
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("mapped_point: no word outstanding, actual %h", rsp_mapped_point);
               fail_tally <= fail_tally + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_mapped_point !== want) begin
                  $error("mapped_point: expected %h, actual %h", want, rsp_mapped_point);
                  fail_tally <= fail_tally + 1;
               end
            end
         end
      end
      queued <= expected_points.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_math_variant_code_point_map.sv =====
// ============================================================================
// tb_math_variant_code_point_map: testbench top for the math style map
// Drives a directed set of edge and special-case words, then a long random
// stream biased toward letters, digits, Greek and Arabic, with random gaps
// on the request side. A checker beside the block predicts every result.
// ============================================================================
`default_nettype none

module tb_math_variant_code_point_map
   import mvcp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Styles that the package leaves unnamed; script, fraktur and
   // double-struck hold most of the Latin gaps.
   localparam logic [ModeWidth-1:0] ModeScript      = 5'd4;
   localparam logic [ModeWidth-1:0] ModeFraktur     = 5'd6;
   localparam logic [ModeWidth-1:0] ModeBoldFraktur = 5'd8;
   localparam logic [ModeWidth-1:0] ModeLast        = 5'd31;

   localparam int unsigned RandomWords = 1400;
   localparam int unsigned QuietFirst  = 500;
   localparam int unsigned QuietLast   = 899;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CpWidth-1:0]   req_code_point;
   logic [ModeWidth-1:0] req_mode;
   logic                 rsp_valid;
   logic [CpWidth-1:0]   rsp_mapped_point;
   int unsigned          mismatches;
   int unsigned          outstanding;

   logic [ModeWidth-1:0] gap_modes [5] =
      '{ModeItalic, ModeScript, ModeFraktur, ModeDouble, ModeBoldFraktur};
   logic [ModeWidth-1:0] arabic_modes [5] =
      '{ModeDouble, ModeInitial, ModeTailed, ModeLooped, ModeStretched};
   // Greek symbols outside the two alphabets, plus the capital gap and the one-style oddities
   logic [CpWidth-1:0]   greek_marks [14] =
      '{21'h03F4, 21'h2207, 21'h2202, 21'h03F5, 21'h03D1, 21'h03F0, 21'h03D5,
        21'h03F1, 21'h03D6, 21'h03A2, 21'h03DC, 21'h03DD, 21'h0131, 21'h0237};
   // Arabic letters that sit outside the main run of table keys
   logic [CpWidth-1:0]   arabic_strays [4] = '{21'h066E, 21'h066F, 21'h06A1, 21'h06BA};

   math_variant_code_point_map uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_code_point   (req_code_point),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_mapped_point (rsp_mapped_point)
   );

   mapped_point_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_code_point   (req_code_point),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_mapped_point (rsp_mapped_point),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Present one word at the falling edge and hold it until the block takes
   // it; busy is read before the edge's register updates land.
   task automatic send_word(input logic [CpWidth-1:0] cp, input logic [ModeWidth-1:0] mode);
      @(negedge clock);
      start          <= 1'b1;
      req_code_point <= cp;
      req_mode       <= mode;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and scramble the payload so that a block that ignores
   // start would show up as a bad result.
   task automatic hold_off(input int unsigned cycles);
      @(negedge clock);
      start          <= 1'b0;
      req_code_point <= CpWidth'($urandom);
      req_mode       <= ModeWidth'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Draw one word: mostly characters that some style maps, with modes
   // leaning toward the styles that actually apply to them, and a share of
   // raw noise over the whole field range.
   task automatic random_word(output logic [CpWidth-1:0] cp,
                              output logic [ModeWidth-1:0] mode);
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         n  = $urandom_range(51);
         cp = (n < 26) ? CpWidth'(21'h41 + n) : CpWidth'(21'h61 + n - 26);
         mode = $urandom_range(1) ? gap_modes[$urandom_range(4)]
                                  : ModeWidth'($urandom_range(19));
      end else if (pick < 42) begin
         cp   = CpWidth'(21'h30 + $urandom_range(9));
         mode = ModeWidth'($urandom_range(19));
      end else if (pick < 62) begin
         cp   = $urandom_range(2) ? CpWidth'($urandom_range(21'h3C9, 21'h391))
                                  : greek_marks[$urandom_range(13)];
         mode = ModeWidth'($urandom_range(14));
      end else if (pick < 85) begin
         n = $urandom_range(9);
         if (n < 6)      cp = CpWidth'($urandom_range(21'h64A, 21'h627));
         else if (n < 8) cp = arabic_strays[$urandom_range(3)];
         else            cp = CpWidth'($urandom_range(21'h6FF, 21'h600));
         mode = ($urandom_range(4) != 0) ? arabic_modes[$urandom_range(4)]
                                         : ModeWidth'($urandom_range(31));
      end else begin
         cp   = CpWidth'($urandom_range(21'h1FFFFF));
         mode = ModeWidth'($urandom_range(31));
      end
   endtask

   initial begin : stimulus
      logic [CpWidth-1:0]   cp;
      logic [ModeWidth-1:0] mode;

      reset          = 1'b1;
      start          = 1'b0;
      req_code_point = '0;
      req_mode       = ModeNormal;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes and the corner cases of each family
      send_word(21'h000000, ModeNormal);        // normal style passes through
      send_word(21'h000041, ModeLast);          // style code past stretched
      send_word(21'h1FFFFF, ModeBold);          // beyond the Unicode range
      send_word(21'h110000, ModeItalic);
      send_word(21'h0003A2, ModeBold);          // gap in the capital Greek run
      send_word(21'h0003DC, ModeBold);          // digamma, bold only
      send_word(21'h0003DD, ModeItalic);
      send_word(21'h000131, ModeItalic);        // dotless i and j, italic only
      send_word(21'h000237, ModeBold);
      send_word(21'h000068, ModeItalic);        // italic h lands on a gap
      send_word(21'h00005A, ModeMono);
      send_word(21'h000061, ModeBold);
      send_word(21'h00007A, ModeInitial);       // Latin has no Arabic styles
      send_word(21'h000030, ModeDouble);
      send_word(21'h000039, ModeMono);
      send_word(21'h000035, ModeItalic);        // no italic digits
      send_word(21'h000391, ModeBold);
      send_word(21'h0003C9, ModeSansBoldItal);
      send_word(21'h002207, ModeBoldSans);
      send_word(21'h000391, ModeSans);          // no plain sans Greek
      send_word(21'h000628, ModeInitial);
      send_word(21'h0006BA, ModeTailed);
      send_word(21'h0006A1, ModeStretched);
      send_word(21'h000600, ModeLooped);        // Arabic with no table entry
      send_word(21'h00064A, ModeDouble);
      send_word(21'h000628, ModeBold);          // Arabic has no bold

      // Random stream; one stretch in the middle runs back to back
      for (int unsigned i = 0; i < RandomWords; i++) begin
         if ((i < QuietFirst || i > QuietLast) && $urandom_range(99) < 6)
            hold_off($urandom_range(4, 1));
         random_word(cp, mode);
         send_word(cp, mode);
      end

      @(negedge clock);
      start <= 1'b0;

      // Drain: wait out every prediction, then keep watching for strays
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: a clean run needs well under a tenth of this
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

// ===== math_variant_code_point_map.f =====
rtl/mvcp_pkg.sv
rtl/mvcp_map.sv
rtl/math_variant_code_point_map.sv
tb/mapped_point_checker.sv
tb/tb_math_variant_code_point_map.sv
